// ===== rtl/dss_pkg.sv =====
// shared types, constants and tables for the dispense stepper sequencer
// no dependencies
package dss_pkg;

  localparam int MAX_SLOTS     = 8;
  localparam int NUM_SLOTS_DEF = 8;
  localparam int SLOT_BITS     = 3;
  localparam int COUNT_BITS    = 4;
  localparam int WIDTH_BITS    = 12;
  localparam int SPS_BITS      = 8;
  localparam int STEP_BITS     = 11;
  localparam int TOTAL_BITS    = 7;
  localparam int STAGE_BITS    = 4;
  localparam int OP_BITS       = 3;
  localparam int CFG_IDX_BITS  = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_START       = 3'd0,
    OP_REFILL_SEL  = 3'd1,
    OP_REFILL_DONE = 3'd2,
    OP_STAGE_TICK  = 3'd3,
    OP_STEP_TICK   = 3'd4,
    OP_SERVO_TICK  = 3'd5,
    OP_PILL_SEEN   = 3'd6
  } op_t;

  localparam logic [STAGE_BITS-1:0] STAGE_IDLE   = 4'd1;
  localparam logic [STAGE_BITS-1:0] STAGE_SELECT = 4'd2;
  localparam logic [STAGE_BITS-1:0] STAGE_MOVE   = 4'd3;
  localparam logic [STAGE_BITS-1:0] STAGE_LIFT   = 4'd4;
  localparam logic [STAGE_BITS-1:0] STAGE_SERVO  = 4'd5;
  localparam logic [STAGE_BITS-1:0] STAGE_SETTLE = 4'd6;
  localparam logic [STAGE_BITS-1:0] STAGE_LOWER  = 4'd7;
  localparam logic [STAGE_BITS-1:0] STAGE_RETURN = 4'd8;
  localparam logic [STAGE_BITS-1:0] STAGE_FINISH = 4'd9;

  localparam int ARM_STAGE = 0;
  localparam int ARM_STEP  = 1;
  localparam int ARM_SERVO = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_STEPS_PER_SLOT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIFT_UP_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIFT_DOWN_WIDTH = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_ALIGN      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_REST       = 3'd4;

  localparam logic [SPS_BITS-1:0]   STEPS_PER_SLOT_RST = 8'd25;
  localparam logic [WIDTH_BITS-1:0] LIFT_UP_RST        = 12'd2500;
  localparam logic [WIDTH_BITS-1:0] LIFT_DOWN_RST      = 12'd1700;
  localparam logic [WIDTH_BITS-1:0] GATE_ALIGN_RST     = 12'd1000;
  localparam logic [WIDTH_BITS-1:0] GATE_REST_RST      = 12'd1900;

  localparam logic [3:0] COIL_TABLE [4] = '{4'hE, 4'hB, 4'hD, 4'h7};

  typedef struct packed {
    logic [SPS_BITS-1:0]   steps_per_slot;
    logic [WIDTH_BITS-1:0] lift_up_width;
    logic [WIDTH_BITS-1:0] lift_down_width;
    logic [WIDTH_BITS-1:0] gate_align_width;
    logic [WIDTH_BITS-1:0] gate_rest_width;
  } cfg_t;

  typedef struct packed {
    logic [3:0]            coil_pattern;
    logic [WIDTH_BITS-1:0] gate_width;
    logic [WIDTH_BITS-1:0] lift_width;
    logic [STAGE_BITS-1:0] stage_now;
    logic                  stage_timer_on;
    logic                  step_timer_on;
    logic                  servo_timer_on;
    logic [TOTAL_BITS-1:0] pills_left;
    logic [SLOT_BITS-1:0]  slot_now;
    logic                  away_from_home;
  } result_t;

endpackage

// ===== rtl/dss_first_slot.sv =====
// priority encoder: lowest container index with a non-zero count
// depends on dss_pkg
module dss_first_slot #(
  parameter int NUM_SLOTS = dss_pkg::NUM_SLOTS_DEF
) (
  input  logic [dss_pkg::COUNT_BITS-1:0] counts [NUM_SLOTS],
  output logic                           found,
  output logic [dss_pkg::SLOT_BITS-1:0]  index
);

  always_comb begin
    found = 1'b0;
    index = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (counts[i] != '0) begin
        found = 1'b1;
        index = dss_pkg::SLOT_BITS'(i);
      end
    end
  end

endmodule

// ===== rtl/dss_cfg_regs.sv =====
// configuration registers with index decode
// depends on dss_pkg
module dss_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [dss_pkg::CFG_IDX_BITS-1:0] wr_index,
  input  logic [dss_pkg::WIDTH_BITS-1:0]   wr_data,
  output dss_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steps_per_slot   <= dss_pkg::STEPS_PER_SLOT_RST;
      cfg.lift_up_width    <= dss_pkg::LIFT_UP_RST;
      cfg.lift_down_width  <= dss_pkg::LIFT_DOWN_RST;
      cfg.gate_align_width <= dss_pkg::GATE_ALIGN_RST;
      cfg.gate_rest_width  <= dss_pkg::GATE_REST_RST;
    end else if (wr_en) begin
      case (wr_index)
        dss_pkg::CFG_STEPS_PER_SLOT:
          cfg.steps_per_slot <= wr_data[dss_pkg::SPS_BITS-1:0];
        dss_pkg::CFG_LIFT_UP_WIDTH:   cfg.lift_up_width    <= wr_data;
        dss_pkg::CFG_LIFT_DOWN_WIDTH: cfg.lift_down_width  <= wr_data;
        dss_pkg::CFG_GATE_ALIGN:      cfg.gate_align_width <= wr_data;
        dss_pkg::CFG_GATE_REST:       cfg.gate_rest_width  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/dss_core.sv =====
// sequencer state and combinational event update
// depends on dss_pkg and dss_first_slot
module dss_core #(
  parameter int NUM_SLOTS = dss_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  dss_pkg::cfg_t                  cfg,
  input  logic [dss_pkg::OP_BITS-1:0]    op,
  input  logic [dss_pkg::COUNT_BITS-1:0] count_in [dss_pkg::MAX_SLOTS],
  output dss_pkg::result_t               result
);

  localparam int IDX_BITS = $clog2(NUM_SLOTS);

  logic [dss_pkg::STAGE_BITS-1:0] stage, stage_next;
  logic                           refill_mode, refill_next;
  logic [dss_pkg::SLOT_BITS-1:0]  slot, slot_next;
  logic [dss_pkg::STEP_BITS-1:0]  steps_left, steps_next;
  logic                           turn_back, turn_next;
  logic [1:0]                     phase, phase_next;
  logic                           away, away_next;
  logic                           returning, returning_next;
  logic [dss_pkg::COUNT_BITS-1:0] pills_here, here_next;
  logic [dss_pkg::TOTAL_BITS-1:0] pills_total, total_next;
  logic                           gate_phase, gate_phase_next;
  logic                           pill_flag, flag_next;
  logic [3:0]                     coil, coil_next;
  logic [dss_pkg::WIDTH_BITS-1:0] gate_w, gate_next;
  logic [dss_pkg::WIDTH_BITS-1:0] lift_w, lift_next;
  logic [2:0]                     arms, arms_next;
  logic [dss_pkg::COUNT_BITS-1:0] counts [NUM_SLOTS];
  logic [dss_pkg::COUNT_BITS-1:0] counts_next [NUM_SLOTS];
  logic [dss_pkg::COUNT_BITS-1:0] count_used [NUM_SLOTS];

  logic                          in_found, held_found, busy, do_motion;
  logic [dss_pkg::SLOT_BITS-1:0] in_first, held_first;
  logic [dss_pkg::TOTAL_BITS-1:0] in_sum;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      count_used[i] = count_in[i];
    end
  end

  always_comb begin
    in_sum = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      in_sum = in_sum + dss_pkg::TOTAL_BITS'(count_in[i]);
    end
  end

  dss_first_slot #(.NUM_SLOTS(NUM_SLOTS)) u_first_in (
    .counts (count_used),
    .found  (in_found),
    .index  (in_first)
  );

  dss_first_slot #(.NUM_SLOTS(NUM_SLOTS)) u_first_held (
    .counts (counts),
    .found  (held_found),
    .index  (held_first)
  );

  assign busy = (stage != dss_pkg::STAGE_IDLE) || arms[dss_pkg::ARM_STEP] || away;

  always_comb begin
    stage_next      = stage;
    refill_next     = refill_mode;
    slot_next       = slot;
    steps_next      = steps_left;
    turn_next       = turn_back;
    phase_next      = phase;
    away_next       = away;
    returning_next  = returning;
    here_next       = pills_here;
    total_next      = pills_total;
    gate_phase_next = gate_phase;
    flag_next       = pill_flag;
    coil_next       = coil;
    gate_next       = gate_w;
    lift_next       = lift_w;
    arms_next       = arms;
    counts_next     = counts;
    do_motion       = 1'b0;

    case (dss_pkg::op_t'(op))
      dss_pkg::OP_START: begin
        if (!busy && in_found) begin
          counts_next    = count_used;
          total_next     = in_sum;
          refill_next    = 1'b0;
          returning_next = 1'b0;
          stage_next     = dss_pkg::STAGE_SELECT;
          arms_next[dss_pkg::ARM_STAGE] = 1'b1;
        end
      end
      dss_pkg::OP_REFILL_SEL: begin
        if (!busy && in_found) begin
          refill_next = 1'b1;
          slot_next   = in_first;
          do_motion   = 1'b1;
        end
      end
      dss_pkg::OP_REFILL_DONE: begin
        if (refill_mode && away && (stage == dss_pkg::STAGE_IDLE) &&
            !arms[dss_pkg::ARM_STEP]) begin
          do_motion = 1'b1;
        end
      end
      dss_pkg::OP_STAGE_TICK: begin
        if (arms[dss_pkg::ARM_STAGE]) begin
          arms_next[dss_pkg::ARM_STAGE] = 1'b0;
          case (stage)
            dss_pkg::STAGE_SELECT: begin
              if (held_found) begin
                slot_next = held_first;
              end
              stage_next = stage + 4'd1;
              arms_next[dss_pkg::ARM_STAGE] = 1'b1;
            end
            dss_pkg::STAGE_MOVE: begin
              do_motion = 1'b1;
            end
            dss_pkg::STAGE_LIFT: begin
              lift_next  = cfg.lift_up_width;
              here_next  = counts[slot[IDX_BITS-1:0]];
              stage_next = stage + 4'd1;
              arms_next[dss_pkg::ARM_STAGE] = 1'b1;
            end
            dss_pkg::STAGE_SERVO: begin
              arms_next[dss_pkg::ARM_SERVO] = 1'b1;
            end
            dss_pkg::STAGE_SETTLE: begin
              stage_next = stage + 4'd1;
              arms_next[dss_pkg::ARM_STAGE] = 1'b1;
            end
            dss_pkg::STAGE_LOWER: begin
              lift_next  = cfg.lift_down_width;
              stage_next = stage + 4'd1;
              arms_next[dss_pkg::ARM_STAGE] = 1'b1;
            end
            dss_pkg::STAGE_RETURN: begin
              returning_next = 1'b1;
              counts_next[slot[IDX_BITS-1:0]] = '0;
              do_motion = 1'b1;
            end
            dss_pkg::STAGE_FINISH: begin
              if (pills_total != '0) begin
                stage_next = dss_pkg::STAGE_SELECT;
                arms_next[dss_pkg::ARM_STAGE] = 1'b1;
              end else begin
                stage_next = dss_pkg::STAGE_IDLE;
              end
              returning_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      dss_pkg::OP_STEP_TICK: begin
        if (arms[dss_pkg::ARM_STEP]) begin
          if (steps_left != '0) begin
            phase_next = turn_back ? phase + 2'd3 : phase + 2'd1;
            steps_next = steps_left - 11'd1;
            coil_next  = dss_pkg::COIL_TABLE[phase_next];
          end else begin
            arms_next[dss_pkg::ARM_STEP] = 1'b0;
            away_next = ~away;
            if (!refill_mode) begin
              do_motion = 1'b1;
            end
          end
        end
      end
      dss_pkg::OP_SERVO_TICK: begin
        if (arms[dss_pkg::ARM_SERVO]) begin
          if (!gate_phase) begin
            gate_next       = cfg.gate_align_width;
            gate_phase_next = 1'b1;
          end else begin
            gate_next       = cfg.gate_rest_width;
            gate_phase_next = 1'b0;
            if (pill_flag) begin
              flag_next = 1'b0;
              if (pills_here != '0) begin
                here_next = pills_here - 4'd1;
              end
              if (pills_total != '0) begin
                total_next = pills_total - 7'd1;
              end
              if (here_next == '0) begin
                arms_next[dss_pkg::ARM_SERVO] = 1'b0;
                stage_next = stage + 4'd1;
                arms_next[dss_pkg::ARM_STAGE] = 1'b1;
              end
            end
          end
        end
      end
      dss_pkg::OP_PILL_SEEN: begin
        flag_next = 1'b1;
      end
      default: ;
    endcase

    // carousel move or next stage
    if (do_motion) begin
      if (refill_next || (away_next == returning_next)) begin
        turn_next  = away_next ? ~turn_next : 1'b0;
        steps_next = dss_pkg::STEP_BITS'(slot_next) *
                     dss_pkg::STEP_BITS'(cfg.steps_per_slot);
        arms_next[dss_pkg::ARM_STEP] = 1'b1;
      end else begin
        stage_next = stage_next + 4'd1;
        arms_next[dss_pkg::ARM_STAGE] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= dss_pkg::STAGE_IDLE;
      refill_mode <= 1'b0;
      slot        <= '0;
      steps_left  <= '0;
      turn_back   <= 1'b0;
      phase       <= '0;
      away        <= 1'b0;
      returning   <= 1'b0;
      pills_here  <= '0;
      pills_total <= '0;
      gate_phase  <= 1'b0;
      pill_flag   <= 1'b0;
      coil        <= '0;
      gate_w      <= dss_pkg::GATE_REST_RST;
      lift_w      <= dss_pkg::LIFT_DOWN_RST;
      arms        <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        counts[i] <= '0;
      end
    end else if (fire) begin
      stage       <= stage_next;
      refill_mode <= refill_next;
      slot        <= slot_next;
      steps_left  <= steps_next;
      turn_back   <= turn_next;
      phase       <= phase_next;
      away        <= away_next;
      returning   <= returning_next;
      pills_here  <= here_next;
      pills_total <= total_next;
      gate_phase  <= gate_phase_next;
      pill_flag   <= flag_next;
      coil        <= coil_next;
      gate_w      <= gate_next;
      lift_w      <= lift_next;
      arms        <= arms_next;
      counts      <= counts_next;
    end
  end

  always_comb begin
    result.coil_pattern   = coil_next;
    result.gate_width     = gate_next;
    result.lift_width     = lift_next;
    result.stage_now      = stage_next;
    result.stage_timer_on = arms_next[dss_pkg::ARM_STAGE];
    result.step_timer_on  = arms_next[dss_pkg::ARM_STEP];
    result.servo_timer_on = arms_next[dss_pkg::ARM_SERVO];
    result.pills_left     = total_next;
    result.slot_now       = slot_next;
    result.away_from_home = away_next;
  end

endmodule

// ===== rtl/dispense_stepper_sequencer.sv =====
// top level of the dispense stepper sequencer: input register, core, result register
// depends on dss_pkg, dss_cfg_regs and dss_core
//
// usage:
//   event channel: opcode plus eight container counts, item_valid / item_stall;
//   a transaction happens when item_valid is high and item_stall is low
//   result channel: one result per event, result_valid / result_stall; the
//   result shows the sequencer state right after the event
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high, write only while the block is idle
//   pipeline: the event is held in the input register; its result is loaded into
//   the result register, raising result_valid, once that register is empty or taken;
//   throughput one event per cycle while result_stall is low, set by the combinational
//   update; a new event is taken while a result still waits in the result register
//   reset: synchronous, clears both registers' valid flags, the sequence state
//   and the container counts, and loads the configuration defaults
//   when result_stall is high the result register holds; once the input
//   register is also full, item_stall rises until the result is taken
module dispense_stepper_sequencer #(
  parameter int NUM_SLOTS = dss_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [dss_pkg::OP_BITS-1:0]       opcode,
  input  logic [dss_pkg::COUNT_BITS-1:0]    count_a,
  input  logic [dss_pkg::COUNT_BITS-1:0]    count_b,
  input  logic [dss_pkg::COUNT_BITS-1:0]    count_c,
  input  logic [dss_pkg::COUNT_BITS-1:0]    count_d,
  input  logic [dss_pkg::COUNT_BITS-1:0]    count_e,
  input  logic [dss_pkg::COUNT_BITS-1:0]    count_f,
  input  logic [dss_pkg::COUNT_BITS-1:0]    count_g,
  input  logic [dss_pkg::COUNT_BITS-1:0]    count_h,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [3:0]                        coil_pattern,
  output logic [dss_pkg::WIDTH_BITS-1:0]    gate_width,
  output logic [dss_pkg::WIDTH_BITS-1:0]    lift_width,
  output logic [dss_pkg::STAGE_BITS-1:0]    stage_now,
  output logic                              stage_timer_on,
  output logic                              step_timer_on,
  output logic                              servo_timer_on,
  output logic [dss_pkg::TOTAL_BITS-1:0]    pills_left,
  output logic [dss_pkg::SLOT_BITS-1:0]     slot_now,
  output logic                              away_from_home,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dss_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [dss_pkg::WIDTH_BITS-1:0]    cfg_data
);

  logic                           item_full, item_full_next;
  logic [dss_pkg::OP_BITS-1:0]    item_op;
  logic [dss_pkg::COUNT_BITS-1:0] item_counts [dss_pkg::MAX_SLOTS];
  logic                           accept, fire, result_valid_next;
  dss_pkg::cfg_t                  cfg;
  dss_pkg::result_t               core_result, result;

  assign cfg_ready  = 1'b1;
  assign fire       = item_full && (!result_valid || !result_stall);
  assign item_stall = item_full && !fire;
  assign accept     = item_valid && !item_stall;

  assign item_full_next    = accept || (item_full && !fire);
  assign result_valid_next = fire || (result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      item_full    <= item_full_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op        <= opcode;
      item_counts[0] <= count_a;
      item_counts[1] <= count_b;
      item_counts[2] <= count_c;
      item_counts[3] <= count_d;
      item_counts[4] <= count_e;
      item_counts[5] <= count_f;
      item_counts[6] <= count_g;
      item_counts[7] <= count_h;
    end
    if (fire) begin
      result <= core_result;
    end
  end

  dss_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dss_core #(.NUM_SLOTS(NUM_SLOTS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .cfg      (cfg),
    .op       (item_op),
    .count_in (item_counts),
    .result   (core_result)
  );

  assign coil_pattern   = result.coil_pattern;
  assign gate_width     = result.gate_width;
  assign lift_width     = result.lift_width;
  assign stage_now      = result.stage_now;
  assign stage_timer_on = result.stage_timer_on;
  assign step_timer_on  = result.step_timer_on;
  assign servo_timer_on = result.servo_timer_on;
  assign pills_left     = result.pills_left;
  assign slot_now       = result.slot_now;
  assign away_from_home = result.away_from_home;

endmodule

// ===== tb/sv/dispense_stepper_sequencer_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for dispense_stepper_sequencer: directed table, then random event runs
// over four register settings; every status word is checked against a cycle-free sequencer model
// depends on dss_pkg and the rtl of dispense_stepper_sequencer
module dispense_stepper_sequencer_tb;
  import dss_pkg::*;

  localparam int NSLOTS = NUM_SLOTS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;
  localparam logic [3:0] COIL_SEQ [4] = '{4'hE, 4'hB, 4'hD, 4'h7};

  typedef logic [7:0][COUNT_BITS-1:0] counts_t;

  localparam counts_t NO_PILLS  = 32'h0000_0000;
  localparam counts_t FULL_LOAD = 32'hFFFF_FFFF;
  localparam counts_t ONLY_F    = 32'h00F0_0000;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    counts_t               cnts;
    logic                  typed;
    logic [STAGE_BITS-1:0] t_stage;
    logic [TOTAL_BITS-1:0] t_pills;
    logic [SLOT_BITS-1:0]  t_slot;
  } drill_row_t;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic [OP_BITS-1:0] opcode;
  logic [COUNT_BITS-1:0] count_a, count_b, count_c, count_d;
  logic [COUNT_BITS-1:0] count_e, count_f, count_g, count_h;
  logic result_valid;
  logic result_stall;
  logic [3:0] coil_pattern;
  logic [WIDTH_BITS-1:0] gate_width;
  logic [WIDTH_BITS-1:0] lift_width;
  logic [STAGE_BITS-1:0] stage_now;
  logic stage_timer_on;
  logic step_timer_on;
  logic servo_timer_on;
  logic [TOTAL_BITS-1:0] pills_left;
  logic [SLOT_BITS-1:0] slot_now;
  logic away_from_home;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [WIDTH_BITS-1:0] cfg_data;

  // sequencer model state
  logic [SPS_BITS-1:0]   cfg_sps;
  logic [WIDTH_BITS-1:0] cfg_lift_up, cfg_lift_down, cfg_gate_align, cfg_gate_rest;
  logic [STAGE_BITS-1:0] seq_stage;
  logic                  refill_on;
  counts_t               bin_count;
  logic [SLOT_BITS-1:0]  bin_sel;
  logic [STEP_BITS-1:0]  steps_to_go;
  logic                  reverse_dir;
  logic [1:0]            phase_ptr;
  logic                  is_away;
  logic                  homing;
  logic [COUNT_BITS-1:0] pills_in_bin;
  logic [TOTAL_BITS-1:0] pills_pending;
  logic                  gate_aligned;
  logic                  pill_latched;
  logic [3:0]            coil_q;
  logic [WIDTH_BITS-1:0] gate_q, lift_q;
  logic [2:0]            arms;

  result_t status_queue [$];

  int mismatches = 0;
  int words_checked = 0;
  int events_sent = 0;
  int starts_taken = 0;
  int reg_writes = 0;
  int test_phase = 0;
  int quiet_cycles = 0;
  bit long_hold_done = 1'b0;

  drill_row_t drill_rows [24] = '{
    '{OP_STAGE_TICK,  NO_PILLS,  1'b1, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   NO_PILLS,  1'b1, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_SERVO_TICK,  NO_PILLS,  1'b1, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_START,       NO_PILLS,  1'b1, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_REFILL_SEL,  NO_PILLS,  1'b1, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_REFILL_DONE, FULL_LOAD, 1'b1, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_UNUSED,      FULL_LOAD, 1'b1, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_PILL_SEEN,   NO_PILLS,  1'b1, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_REFILL_SEL,  ONLY_F,    1'b1, STAGE_IDLE,   7'd0,   3'd5},
    '{OP_STEP_TICK,   NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   FULL_LOAD, 1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   FULL_LOAD, 1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_START,       FULL_LOAD, 1'b1, STAGE_IDLE,   7'd0,   3'd5},
    '{OP_REFILL_DONE, NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_STEP_TICK,   NO_PILLS,  1'b0, STAGE_IDLE,   7'd0,   3'd0},
    '{OP_START,       FULL_LOAD, 1'b1, STAGE_SELECT, 7'd120, 3'd5}
  };

  dispense_stepper_sequencer uut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .opcode         (opcode),
    .count_a        (count_a),
    .count_b        (count_b),
    .count_c        (count_c),
    .count_d        (count_d),
    .count_e        (count_e),
    .count_f        (count_f),
    .count_g        (count_g),
    .count_h        (count_h),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .coil_pattern   (coil_pattern),
    .gate_width     (gate_width),
    .lift_width     (lift_width),
    .stage_now      (stage_now),
    .stage_timer_on (stage_timer_on),
    .step_timer_on  (step_timer_on),
    .servo_timer_on (servo_timer_on),
    .pills_left     (pills_left),
    .slot_now       (slot_now),
    .away_from_home (away_from_home),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int first_loaded(input counts_t c);
    for (int i = 0; i < NSLOTS; i++) begin
      if (c[i] != 0) return i;
    end
    return -1;
  endfunction

  task automatic reset_sequencer_model();
    cfg_sps = STEPS_PER_SLOT_RST;
    cfg_lift_up = LIFT_UP_RST;
    cfg_lift_down = LIFT_DOWN_RST;
    cfg_gate_align = GATE_ALIGN_RST;
    cfg_gate_rest = GATE_REST_RST;
    seq_stage = STAGE_IDLE;
    refill_on = 1'b0;
    bin_count = '0;
    bin_sel = '0;
    steps_to_go = '0;
    reverse_dir = 1'b0;
    phase_ptr = '0;
    is_away = 1'b0;
    homing = 1'b0;
    pills_in_bin = '0;
    pills_pending = '0;
    gate_aligned = 1'b0;
    pill_latched = 1'b0;
    coil_q = '0;
    gate_q = GATE_REST_RST;
    lift_q = LIFT_DOWN_RST;
    arms = '0;
  endtask

  task automatic raise_stage();
    seq_stage = seq_stage + 4'd1;
    arms[ARM_STAGE] = 1'b1;
  endtask

  task automatic start_move(input logic rev);
    reverse_dir = rev ? ~reverse_dir : 1'b0;
    steps_to_go = bin_sel * cfg_sps;
    arms[ARM_STEP] = 1'b1;
  endtask

  task automatic carousel_next();
    if (refill_on) begin
      start_move(is_away);
    end else if (is_away == homing) begin
      start_move(is_away);
    end else begin
      raise_stage();
    end
  endtask

  task automatic stage_event();
    int f;
    arms[ARM_STAGE] = 1'b0;
    case (seq_stage)
      STAGE_SELECT: begin
        f = first_loaded(bin_count);
        if (f >= 0) bin_sel = f[SLOT_BITS-1:0];
        raise_stage();
      end
      STAGE_MOVE: carousel_next();
      STAGE_LIFT: begin
        lift_q = cfg_lift_up;
        pills_in_bin = bin_count[bin_sel];
        raise_stage();
      end
      STAGE_SERVO: arms[ARM_SERVO] = 1'b1;
      STAGE_SETTLE: raise_stage();
      STAGE_LOWER: begin
        lift_q = cfg_lift_down;
        raise_stage();
      end
      STAGE_RETURN: begin
        homing = 1'b1;
        bin_count[bin_sel] = '0;
        carousel_next();
      end
      STAGE_FINISH: begin
        if (pills_pending > 0) begin
          seq_stage = STAGE_SELECT;
          arms[ARM_STAGE] = 1'b1;
        end else begin
          seq_stage = STAGE_IDLE;
        end
        homing = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic step_event();
    if (steps_to_go > 0) begin
      phase_ptr = reverse_dir ? phase_ptr - 2'd1 : phase_ptr + 2'd1;
      steps_to_go = steps_to_go - 1'b1;
      coil_q = COIL_SEQ[phase_ptr];
    end else begin
      arms[ARM_STEP] = 1'b0;
      is_away = ~is_away;
      if (!refill_on) carousel_next();
    end
  endtask

  task automatic servo_event();
    if (!gate_aligned) begin
      gate_q = cfg_gate_align;
      gate_aligned = 1'b1;
    end else begin
      gate_q = cfg_gate_rest;
      gate_aligned = 1'b0;
      if (pill_latched) begin
        pill_latched = 1'b0;
        if (pills_in_bin > 0) pills_in_bin = pills_in_bin - 1'b1;
        if (pills_pending > 0) pills_pending = pills_pending - 1'b1;
        if (pills_in_bin == 0) begin
          arms[ARM_SERVO] = 1'b0;
          raise_stage();
        end
      end
    end
  endtask

  // advances the sequencer model by one event and returns the status word after it
  task automatic apply_event(input logic [OP_BITS-1:0] op, input counts_t c, output result_t r);
    logic busy;
    int f;
    busy = (seq_stage != STAGE_IDLE) || arms[ARM_STEP] || is_away;
    f = first_loaded(c);
    case (op)
      OP_START: begin
        if (!busy && f >= 0) begin
          pills_pending = '0;
          for (int i = 0; i < 8; i++) begin
            bin_count[i] = (i < NSLOTS) ? c[i] : '0;
            pills_pending = pills_pending + 7'(bin_count[i]);
          end
          refill_on = 1'b0;
          homing = 1'b0;
          seq_stage = STAGE_SELECT;
          arms[ARM_STAGE] = 1'b1;
          starts_taken++;
        end
      end
      OP_REFILL_SEL: begin
        if (!busy && f >= 0) begin
          refill_on = 1'b1;
          bin_sel = f[SLOT_BITS-1:0];
          carousel_next();
        end
      end
      OP_REFILL_DONE: begin
        if (refill_on && is_away && seq_stage == STAGE_IDLE && !arms[ARM_STEP]) carousel_next();
      end
      OP_STAGE_TICK: if (arms[ARM_STAGE]) stage_event();
      OP_STEP_TICK: if (arms[ARM_STEP]) step_event();
      OP_SERVO_TICK: if (arms[ARM_SERVO]) servo_event();
      OP_PILL_SEEN: pill_latched = 1'b1;
      default: ;
    endcase
    r.coil_pattern = coil_q;
    r.gate_width = gate_q;
    r.lift_width = lift_q;
    r.stage_now = seq_stage;
    r.stage_timer_on = arms[ARM_STAGE];
    r.step_timer_on = arms[ARM_STEP];
    r.servo_timer_on = arms[ARM_SERVO];
    r.pills_left = pills_pending;
    r.slot_now = bin_sel;
    r.away_from_home = is_away;
  endtask

  function automatic logic sender_waits();
    case (test_phase)
      0: return $urandom_range(99) < 23;
      1: return $urandom_range(99) < 48;
      default: return 1'b0;
    endcase
  endfunction

  // all calls start and end just after a falling edge
  task automatic offer(input logic [OP_BITS-1:0] op, input counts_t c, input logic typed,
                       input logic [STAGE_BITS-1:0] t_stage, input logic [TOTAL_BITS-1:0] t_pills,
                       input logic [SLOT_BITS-1:0] t_slot);
    result_t want;
    while (sender_waits()) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    opcode = op;
    {count_h, count_g, count_f, count_e, count_d, count_c, count_b, count_a} = c;
    item_valid = 1'b1;
    apply_event(op, c, want);
    if (typed) begin
      want.stage_now = t_stage;
      want.pills_left = t_pills;
      want.slot_now = t_slot;
    end
    status_queue.push_back(want);
    @(posedge clk);
    while (item_stall) @(posedge clk);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [WIDTH_BITS-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      CFG_STEPS_PER_SLOT:  cfg_sps = val[SPS_BITS-1:0];
      CFG_LIFT_UP_WIDTH:   cfg_lift_up = val;
      CFG_LIFT_DOWN_WIDTH: cfg_lift_down = val;
      CFG_GATE_ALIGN:      cfg_gate_align = val;
      CFG_GATE_REST:       cfg_gate_rest = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_settings(input logic [SPS_BITS-1:0] sps, input logic [WIDTH_BITS-1:0] lu,
                               input logic [WIDTH_BITS-1:0] ld, input logic [WIDTH_BITS-1:0] ga,
                               input logic [WIDTH_BITS-1:0] gr);
    write_reg(CFG_STEPS_PER_SLOT, {4'd0, sps});
    write_reg(CFG_LIFT_UP_WIDTH, lu);
    write_reg(CFG_LIFT_DOWN_WIDTH, ld);
    write_reg(CFG_GATE_ALIGN, ga);
    write_reg(CFG_GATE_REST, gr);
  endtask

  task automatic drain();
    item_valid = 1'b0;
    while (status_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic counts_t random_load();
    counts_t c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(99) < 22)
        c[i] = ($urandom_range(19) == 0) ? 4'd15 : 4'($urandom_range(1, 3));
    end
    // long step spacing: keep new runs close to home
    if (test_phase == 3) c[7:2] = '0;
    return c;
  endfunction

  // mostly the events a real timer and sensor setup would produce, plus some noise
  task automatic choose_event(output logic [OP_BITS-1:0] op, output counts_t c);
    logic [OP_BITS-1:0] armed [$];
    c = random_load();
    if ($urandom_range(99) < 8) begin
      op = 3'($urandom_range(7));
      c = $urandom();
    end else if (seq_stage == STAGE_IDLE && !arms[ARM_STEP] && !is_away) begin
      op = ($urandom_range(4) == 0) ? OP_REFILL_SEL : OP_START;
    end else if (refill_on && is_away && seq_stage == STAGE_IDLE && !arms[ARM_STEP]) begin
      op = OP_REFILL_DONE;
    end else begin
      if (arms[ARM_STAGE]) armed.push_back(OP_STAGE_TICK);
      if (arms[ARM_STEP]) armed.push_back(OP_STEP_TICK);
      if (arms[ARM_SERVO])
        armed.push_back((!pill_latched && $urandom_range(1) == 0) ? OP_PILL_SEEN : OP_SERVO_TICK);
      if (armed.size() == 0) op = 3'($urandom_range(7));
      else op = armed[$urandom_range(armed.size() - 1)];
    end
  endtask

  task automatic random_events(input int n);
    logic [OP_BITS-1:0] op;
    counts_t c;
    for (int k = 0; k < n; k++) begin
      choose_event(op, c);
      offer(op, c, 1'b0, '0, '0, '0);
    end
  endtask

  task automatic compare_field(input string name, input logic [WIDTH_BITS-1:0] want,
                               input logic [WIDTH_BITS-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : status_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (status_queue.size() == 0) begin
        mismatches++;
        $display("%0t: status transaction with nothing expected", $time);
      end else begin
        want = status_queue.pop_front();
        words_checked++;
        compare_field("coil_pattern", want.coil_pattern, coil_pattern);
        compare_field("gate_width", want.gate_width, gate_width);
        compare_field("lift_width", want.lift_width, lift_width);
        compare_field("stage_now", want.stage_now, stage_now);
        compare_field("stage_timer_on", want.stage_timer_on, stage_timer_on);
        compare_field("step_timer_on", want.step_timer_on, step_timer_on);
        compare_field("servo_timer_on", want.servo_timer_on, servo_timer_on);
        compare_field("pills_left", want.pills_left, pills_left);
        compare_field("slot_now", want.slot_now, slot_now);
        compare_field("away_from_home", want.away_from_home, away_from_home);
      end
    end
  end

  // receiver side
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (test_phase == 2 && !long_hold_done) begin
        long_hold_done = 1'b1;
        result_stall = 1'b1;
        repeat (60) @(negedge clk);
      end
      case (test_phase)
        0: result_stall = $urandom_range(99) < 48;
        1: result_stall = $urandom_range(99) < 23;
        default: result_stall = 1'b0;
      endcase
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("no transaction for %0d cycles, %0d status words outstanding",
                 QUIET_LIMIT, status_queue.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    opcode = OP_START;
    {count_h, count_g, count_f, count_e, count_d, count_c, count_b, count_a} = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_STEPS_PER_SLOT;
    cfg_data = '0;
    reset_sequencer_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // short moves so the directed rows reach both phase wraps
    write_reg(CFG_STEPS_PER_SLOT, 12'd1);
    foreach (drill_rows[i])
      offer(drill_rows[i].op, drill_rows[i].cnts, drill_rows[i].typed,
            drill_rows[i].t_stage, drill_rows[i].t_pills, drill_rows[i].t_slot);
    drain();
    write_reg(CFG_STEPS_PER_SLOT, 12'd2);
    random_events(250);

    drain();
    load_settings(8'd1, 12'd4095, 12'd0, 12'd0, 12'd4095);
    test_phase = 1;
    random_events(250);

    drain();
    load_settings(8'($urandom_range(1, 6)), 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                  12'($urandom_range(4095)), 12'($urandom_range(4095)));
    test_phase = 2;
    random_events(250);

    drain();
    load_settings(8'd255, 12'd0, 12'd4095, 12'd4095, 12'd0);
    test_phase = 3;
    random_events(250);

    drain();
    $display("covered %0d events with %0d dispense runs started, %0d status words checked",
             events_sent, starts_taken, words_checked);
    $display("%0d register writes over four settings, step spacing from 1 to 255", reg_writes);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
